[hdl/otsu_histogram_threshold_defines.svh]
// Assertion macros used by the port-level checker file.
`ifndef OTSU_HISTOGRAM_THRESHOLD_DEFINES_SVH
`define OTSU_HISTOGRAM_THRESHOLD_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define OTSU_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("otsu check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define OTSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("otsu check failed");

`endif

[hdl/otsu_pkg.sv]
// Shared types and constants for the Otsu threshold block.
package otsu_pkg;

  // bits of the multiplier operand retired per cycle
  localparam int unsigned MUL_DIGIT = 8;

  typedef enum logic [2:0] {
    S_LOAD,
    S_READ,
    S_ACC,
    S_MSTART,
    S_MWAIT,
    S_DSTART,
    S_DWAIT,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_MT_W,
    OP_M_N,
    OP_SQ,
    OP_DEN,
    OP_LEFT,
    OP_RIGHT
  } op_t;

  typedef struct packed {
    logic in_ready;
    logic ram_re;
    logic mul_start;
    logic div_start;
  } ctrl_t;

endpackage

[hdl/otsu_histogram_threshold.sv]
// Otsu threshold over a streamed histogram, exact integer scoring.
//
//  channel | signals                                             | role
//  in      | in_valid, in_ready, bin_count, last_bin             | one bin per beat
//  out     | out_valid, out_ready, tie_index_sum, tie_count,     | one result per
//          | threshold_index                                     | last_bin beat
//
// Bins load one per cycle into the bin RAM while in_ready is high. A last_bin
// beat starts a walk over the stored bins: per bin a RAM read and accumulate,
// plus up to six passes of the digit-serial multiplier, each through the PW-bit
// operand in 8-bit digits (PW = 2*(COUNT_BITS+log2 BINS)+log2 BINS); then a
// division and a final step to register the result. in_ready is low from the
// last_bin beat until the result is registered; a result not yet taken holds
// the walk at its end. No clearing pass after reset.
module otsu_histogram_threshold #(
  parameter int BINS       = 256,
  parameter int COUNT_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COUNT_BITS-1:0] bin_count,
  input  logic                  last_bin,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [14:0]           tie_index_sum,
  output logic [8:0]            tie_count,
  output logic [7:0]            threshold_index
);

  localparam int CB = COUNT_BITS;
  localparam int IB = $clog2(BINS);
  localparam int LW = $clog2(BINS + 1);
  localparam int NW = CB + IB;      // total pixels
  localparam int MW = NW + IB;      // total moment
  localparam int PW = MW + NW;      // MT*W, M*N
  localparam int QW = 2 * PW;       // squared difference
  localparam int DNW = 2 * NW;      // W*(N-W)
  localparam int XW = QW + PW;      // multiplier product
  localparam int SW = 2 * IB;       // index sum
  localparam int KW = IB + 1;       // tie count

  otsu_pkg::state_t state, state_next;
  otsu_pkg::op_t    op;
  otsu_pkg::ctrl_t  ctrl;

  logic [LW-1:0]  bins_loaded;
  logic [NW-1:0]  total_pixels;
  logic [MW-1:0]  weighted_total;
  logic [IB-1:0]  idx, end_idx;
  logic [NW-1:0]  w;
  logic [MW-1:0]  m;
  logic [PW-1:0]  prod_a, diff;
  logic [QW-1:0]  num, best_num;
  logic [DNW-1:0] den, best_den;
  logic [XW-1:0]  lhs;
  logic           have;
  logic [SW-1:0]  sum;
  logic [KW-1:0]  cnt;

  logic           in_acc, room, skip, at_end, store;
  logic [CB-1:0]  rdata;
  logic [NW-1:0]  w_new;
  logic [QW-1:0]  mul_a;
  logic [PW-1:0]  mul_b;
  logic [XW-1:0]  mul_p;
  logic           mul_done, div_done;
  logic [SW-1:0]  quo;
  logic [SW+14:0] sum_ext;
  logic [KW+8:0]  cnt_ext;
  logic [SW+7:0]  quo_ext;

  assign in_acc = in_valid && ctrl.in_ready;
  assign room   = bins_loaded < LW'(BINS);
  assign store  = in_acc && room;
  assign w_new  = w + NW'(rdata);
  assign skip   = (w_new == '0) || (w_new == total_pixels);
  assign at_end = idx == end_idx;

  otsu_ram #(.WIDTH(CB), .DEPTH(BINS)) u_ram (
    .clk   (clk),
    .we    (store),
    .waddr (bins_loaded[IB-1:0]),
    .wdata (bin_count),
    .re    (ctrl.ram_re),
    .raddr (idx),
    .rdata (rdata)
  );

  always_comb begin
    unique case (op)
      otsu_pkg::OP_MT_W:  begin mul_a = QW'(weighted_total); mul_b = PW'(w); end
      otsu_pkg::OP_M_N:   begin mul_a = QW'(m);              mul_b = PW'(total_pixels); end
      otsu_pkg::OP_SQ:    begin mul_a = QW'(diff);           mul_b = diff; end
      otsu_pkg::OP_DEN:   begin mul_a = QW'(w);              mul_b = PW'(total_pixels - w); end
      otsu_pkg::OP_LEFT:  begin mul_a = num;                 mul_b = PW'(best_den); end
      otsu_pkg::OP_RIGHT: begin mul_a = best_num;            mul_b = PW'(den); end
      default:            begin mul_a = '0;                  mul_b = '0; end
    endcase
  end

  otsu_mul #(.WA(QW), .WB(PW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (ctrl.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  otsu_div #(.NW(SW), .DW(KW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.div_start),
    .dividend (sum),
    .divisor  (cnt),
    .done     (div_done),
    .quotient (quo)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      otsu_pkg::S_LOAD:   if (in_acc && last_bin) state_next = otsu_pkg::S_READ;
      otsu_pkg::S_READ:   state_next = otsu_pkg::S_ACC;
      otsu_pkg::S_ACC: begin
        if (!skip) state_next = otsu_pkg::S_MSTART;
        else if (at_end) state_next = otsu_pkg::S_DSTART;
        else state_next = otsu_pkg::S_READ;
      end
      otsu_pkg::S_MSTART: state_next = otsu_pkg::S_MWAIT;
      otsu_pkg::S_MWAIT: begin
        if (mul_done) begin
          if ((op == otsu_pkg::OP_RIGHT) || (op == otsu_pkg::OP_DEN && !have)) begin
            state_next = at_end ? otsu_pkg::S_DSTART : otsu_pkg::S_READ;
          end else begin
            state_next = otsu_pkg::S_MSTART;
          end
        end
      end
      otsu_pkg::S_DSTART: state_next = otsu_pkg::S_DWAIT;
      otsu_pkg::S_DWAIT:  if (div_done) state_next = otsu_pkg::S_DONE;
      otsu_pkg::S_DONE:   if (!out_valid || out_ready) state_next = otsu_pkg::S_LOAD;
      default:            state_next = otsu_pkg::S_LOAD;
    endcase
  end

  // control outputs
  always_comb begin
    ctrl           = '0;
    ctrl.in_ready  = state == otsu_pkg::S_LOAD;
    ctrl.ram_re    = state == otsu_pkg::S_READ;
    ctrl.mul_start = state == otsu_pkg::S_MSTART;
    ctrl.div_start = state == otsu_pkg::S_DSTART;
  end

  assign in_ready = ctrl.in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= otsu_pkg::S_LOAD;
      bins_loaded    <= '0;
      total_pixels   <= '0;
      weighted_total <= '0;
      out_valid      <= 1'b0;
      have           <= 1'b0;
      op             <= otsu_pkg::OP_MT_W;
    end else begin
      state <= state_next;
      // S_DONE reloads out_valid itself
      if (out_valid && out_ready && state != otsu_pkg::S_DONE) out_valid <= 1'b0;

      unique case (state)
        otsu_pkg::S_LOAD: begin
          if (store) begin
            bins_loaded    <= bins_loaded + LW'(1);
            total_pixels   <= total_pixels + NW'(bin_count);
            weighted_total <= weighted_total
                            + MW'(bin_count) * MW'(bins_loaded[IB-1:0]);
          end
          if (in_acc && last_bin) begin
            have <= 1'b0;
            end_idx <= room ? bins_loaded[IB-1:0] : IB'(BINS - 1);
            idx <= '0;
            w   <= '0;
            m   <= '0;
            sum <= '0;
            cnt <= '0;
          end
        end
        otsu_pkg::S_ACC: begin
          w  <= w_new;
          m  <= m + MW'(rdata) * MW'(idx);
          op <= otsu_pkg::OP_MT_W;
          if (skip && !at_end) idx <= idx + IB'(1);
        end
        otsu_pkg::S_MWAIT: begin
          if (mul_done) begin
            unique case (op)
              otsu_pkg::OP_MT_W: begin
                prod_a <= mul_p[PW-1:0];
                op     <= otsu_pkg::OP_M_N;
              end
              otsu_pkg::OP_M_N: begin
                diff <= (prod_a >= mul_p[PW-1:0]) ? prod_a - mul_p[PW-1:0]
                                                  : mul_p[PW-1:0] - prod_a;
                op   <= otsu_pkg::OP_SQ;
              end
              otsu_pkg::OP_SQ: begin
                num <= mul_p[QW-1:0];
                op  <= otsu_pkg::OP_DEN;
              end
              otsu_pkg::OP_DEN: begin
                den <= mul_p[DNW-1:0];
                op  <= otsu_pkg::OP_LEFT;
                if (!have) begin
                  // first qualifying bin always takes the lead
                  have     <= 1'b1;
                  best_num <= num;
                  best_den <= mul_p[DNW-1:0];
                  sum      <= SW'(idx);
                  cnt      <= KW'(1);
                  if (!at_end) idx <= idx + IB'(1);
                end
              end
              otsu_pkg::OP_LEFT: begin
                lhs <= mul_p;
                op  <= otsu_pkg::OP_RIGHT;
              end
              otsu_pkg::OP_RIGHT: begin
                if (lhs > mul_p) begin
                  best_num <= num;
                  best_den <= den;
                  sum      <= SW'(idx);
                  cnt      <= KW'(1);
                end else if (lhs == mul_p) begin
                  sum <= sum + SW'(idx);
                  cnt <= cnt + KW'(1);
                end
                if (!at_end) idx <= idx + IB'(1);
              end
              default: op <= otsu_pkg::OP_MT_W;
            endcase
          end
        end
        otsu_pkg::S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            tie_index_sum   <= sum_ext[14:0];
            tie_count       <= cnt_ext[8:0];
            threshold_index <= (cnt == '0) ? 8'd0 : quo_ext[7:0];
            bins_loaded     <= '0;
            total_pixels    <= '0;
            weighted_total  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign sum_ext = (SW+15)'(sum);
  assign cnt_ext = (KW+9)'(cnt);
  assign quo_ext = (SW+8)'(quo);

endmodule

[hdl/otsu_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
module otsu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/otsu_mul.sv]
// Digit-serial unsigned multiplier: WA x DW partial product per cycle.
module otsu_mul #(
  parameter int WA = 144,
  parameter int WB = 72
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WA-1:0]    a,
  input  logic [WB-1:0]    b,
  output logic             done,
  output logic [WA+WB-1:0] p
);

  localparam int DW    = otsu_pkg::MUL_DIGIT;
  localparam int STEPS = (WB + DW - 1) / DW;
  localparam int WBP   = STEPS * DW;
  localparam int CW    = $clog2(STEPS + 1);

  logic [WA-1:0]     a_reg;
  logic [WA+WBP-1:0] acc;
  logic [CW-1:0]     cnt;
  logic              busy;
  logic [WA+DW-1:0]  part;

  // high half plus a times the lowest digit; low half shifts out finished bits
  assign part = (WA+DW)'(acc[WA+WBP-1:WBP])
              + (WA+DW)'(a_reg) * (WA+DW)'(acc[DW-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_reg <= a;
      acc   <= {{WA{1'b0}}, WBP'(b)};
    end else if (busy) begin
      acc <= {part, acc[WBP-1:DW]};
    end
  end

  assign p = acc[WA+WB-1:0];

endmodule

[hdl/otsu_div.sv]
// Restoring divider, one quotient bit per cycle.
module otsu_div #(
  parameter int NW = 16,
  parameter int DW = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem, quo[NW-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? DW'(trial - {1'b0, dvs}) : trial[DW-1:0];
      quo <= {quo[NW-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

[hdl/otsu_checker.sv]
// Port-level checks for the Otsu threshold block, bound to the top level.
`include "otsu_histogram_threshold_defines.svh"

module otsu_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        last_bin,
  input logic        out_valid,
  input logic        out_ready,
  input logic [14:0] tie_index_sum,
  input logic [8:0]  tie_count,
  input logic [7:0]  threshold_index
);

  // a pending result beat holds its payload
  `OTSU_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(tie_index_sum) && $stable(tie_count) && $stable(threshold_index))

  // no qualifying bin gives an all-zero result
  `OTSU_ASSERT_NOW(a_none_zero, clk, rst, out_valid && tie_count == 9'd0,
    tie_index_sum == 15'd0 && threshold_index == 8'd0)

  // a single winner is its own threshold
  `OTSU_ASSERT_NOW(a_single, clk, rst, out_valid && tie_count == 9'd1,
    threshold_index == tie_index_sum[7:0])

  // the walk blocks input right after the final bin
  `OTSU_ASSERT_NEXT(a_walk_stall, clk, rst, in_valid && in_ready && last_bin, !in_ready)

endmodule

bind otsu_histogram_threshold otsu_checker u_otsu_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .last_bin        (last_bin),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .tie_index_sum   (tie_index_sum),
  .tie_count       (tie_count),
  .threshold_index (threshold_index)
);

[tb/otsu_histogram_threshold_checker.sv]
// Checker for the Otsu threshold block: predicts each result and compares it.
module otsu_histogram_threshold_checker #(
  parameter int BINS       = 256,
  parameter int COUNT_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [COUNT_BITS-1:0] bin_count,
  input  logic                  last_bin,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [14:0]           tie_index_sum,
  input  logic [8:0]            tie_count,
  input  logic [7:0]            threshold_index,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    logic [14:0] idx_sum;
    logic [8:0]  ties;
    logic [7:0]  thresh;
  } otsu_result_t;

  bit [COUNT_BITS-1:0] hist [BINS];
  bit [63:0]           npix;
  bit [63:0]           moment;
  int unsigned         loaded;
  otsu_result_t        thresholds_due[$];

  // walk the stored bins, exact cross-multiplied comparison of scores
  function automatic otsu_result_t best_split();
    bit [255:0]  w, m, a, b, num, den, best_num, best_den, lhs, rhs, n, mt;
    bit [63:0]   sum, cnt;
    bit          have;
    otsu_result_t r;
    w = 0; m = 0; sum = 0; cnt = 0; have = 0;
    best_num = 0; best_den = 0;
    n = npix; mt = moment;
    for (int i = 0; i < loaded && i < BINS; i++) begin
      w = w + hist[i];
      m = m + hist[i] * i;
      if (w == 0 || w == n) continue;
      a = mt * w;
      b = m * n;
      num = (a >= b) ? a - b : b - a;
      num = num * num;
      den = w * (n - w);
      lhs = num * best_den;
      rhs = best_num * den;
      if (!have || lhs > rhs) begin
        best_num = num; best_den = den; have = 1;
        sum = i; cnt = 1;
      end else if (lhs == rhs) begin
        sum += i;
        cnt++;
      end
    end
    r.idx_sum = sum[14:0];
    r.ties    = cnt[8:0];
    r.thresh  = (cnt != 0) ? 8'(sum / cnt) : 8'd0;
    return r;
  endfunction

  always @(posedge clk) begin
    otsu_result_t exp_r;
    if (rst) begin
      npix = 0;
      moment = 0;
      loaded = 0;
      fail_count <= 0;
      pending <= 0;
      thresholds_due.delete();
    end else begin
      if (in_valid && in_ready) begin
        if (loaded < BINS) begin
          hist[loaded] = bin_count;
          npix = npix + bin_count;
          moment = moment + 64'(bin_count) * loaded;
          loaded++;
        end
        if (last_bin) begin
          thresholds_due.push_back(best_split());
          npix = 0;
          moment = 0;
          loaded = 0;
        end
      end
      if (out_valid && out_ready) begin
        if (thresholds_due.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result beat: sum %0d count %0d thresh %0d",
                     tie_index_sum, tie_count, threshold_index);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = thresholds_due.pop_front();
          if (exp_r.idx_sum !== tie_index_sum || exp_r.ties !== tie_count ||
              exp_r.thresh !== threshold_index) begin
            if (fail_count < 10)
              $display("mismatch: exp sum %0d count %0d thresh %0d, got %0d %0d %0d",
                       exp_r.idx_sum, exp_r.ties, exp_r.thresh,
                       tie_index_sum, tie_count, threshold_index);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= thresholds_due.size();
    end
  end

endmodule

[tb/otsu_histogram_threshold_tb.sv]
// Testbench top for the Otsu threshold block: stimulus and verdict.
module otsu_histogram_threshold_tb;

  localparam int BINS       = 256;
  localparam int COUNT_BITS = 24;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [COUNT_BITS-1:0] bin_count;
  logic                  last_bin;
  logic                  out_valid;
  logic                  out_ready;
  logic [14:0]           tie_index_sum;
  logic [8:0]            tie_count;
  logic [7:0]            threshold_index;
  int                    fail_count;
  int                    pending;
  int                    sent;

  otsu_histogram_threshold #(.BINS(BINS), .COUNT_BITS(COUNT_BITS)) dut (.*);

  otsu_histogram_threshold_checker #(.BINS(BINS), .COUNT_BITS(COUNT_BITS)) checker_i (.*);

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  function automatic int idle_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 65) return 0;
    if (k < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [COUNT_BITS-1:0] rand_count();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return COUNT_BITS'($urandom_range(1, 15));
      2: return '1;
      3: return COUNT_BITS'($urandom_range(1, 4000));
      default: return COUNT_BITS'($urandom);
    endcase
  endfunction

  // one input beat, with an optional gap before it
  task automatic send_bin(input logic [COUNT_BITS-1:0] cnt, input logic last);
    int gap;
    gap = idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    bin_count <= cnt;
    last_bin  <= last;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic send_hist(input int len);
    for (int i = 0; i < len; i++) send_bin(rand_count(), i == len - 1);
  endtask

  // receiver: a long hold-off early on, then random stalls
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    repeat (200) @(negedge clk);
    repeat (3000) @(negedge clk);
    forever begin
      out_ready <= 1'b1;
      @(negedge clk);
      if (idle_len() > 0) begin
        out_ready <= 1'b0;
        repeat (idle_len() + 1) @(negedge clk);
      end
    end
  end

  initial begin
    #20000000;
    $display("otsu_histogram_threshold_tb failed");
    $finish;
  end

  initial begin
    int len;
    sent      = 0;
    rst       = 1'b1;
    in_valid  = 1'b0;
    bin_count = '0;
    last_bin  = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // single bin: W equals N, nothing qualifies
    send_bin('1, 1'b1);
    // all-zero histogram
    send_bin('0, 1'b0); send_bin('0, 1'b0); send_bin('0, 1'b1);
    // full-scale counts
    send_bin('1, 1'b0); send_bin('1, 1'b1);
    // symmetric split gives a tie
    send_bin(24'd5, 1'b0); send_bin('0, 1'b0); send_bin(24'd5, 1'b1);
    send_bin(24'd1, 1'b0); send_bin('1, 1'b0); send_bin('0, 1'b0);
    send_bin(24'd7, 1'b1);
    send_bin(24'hAAAAAA, 1'b0); send_bin(24'h555555, 1'b0);
    send_bin('0, 1'b0); send_bin(24'd3, 1'b1);

    // oversize histogram: counts past the bin limit are dropped
    send_hist(BINS + 20);

    while (sent < 1000) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                          : $urandom_range(1, 12);
      send_hist(len);
    end
    // one more full-size histogram
    send_hist(BINS);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("otsu_histogram_threshold_tb passed");
    else
      $display("otsu_histogram_threshold_tb failed");
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/otsu_pkg.sv
hdl/otsu_ram.sv
hdl/otsu_mul.sv
hdl/otsu_div.sv
hdl/otsu_histogram_threshold.sv
hdl/otsu_checker.sv
tb/otsu_histogram_threshold_checker.sv
tb/otsu_histogram_threshold_tb.sv
